// ----- rtl/adl_pkg.sv -----
// ----------------------------------------------------------------------------
// adl_pkg
// Shared types, constants and the modular fold for the Adler-32 datapath.
// ----------------------------------------------------------------------------
package adl_pkg;

  localparam int unsigned ADL_MAX_LANES = 8;
  localparam int unsigned ADL_CNT_W     = 4;
  localparam int unsigned ADL_PLAIN_W   = 11;   // 8 * 255 fits
  localparam int unsigned ADL_WGT_W     = 14;   // 36 * 255 fits
  localparam int unsigned ADL_RAW_W     = 20;   // b + n*a + weighted fits
  localparam logic [16:0] ADL_MOD       = 17'd65521;

  typedef struct packed {
    logic [ADL_CNT_W-1:0] count;
    logic                 first;
    logic [31:0]          seed;
    logic                 last;
  } adl_ctl_t;

  typedef struct packed {
    adl_ctl_t               ctl;
    logic [ADL_PLAIN_W-1:0] plain;
    logic [ADL_WGT_W-1:0]   weighted;
  } adl_s2_t;

  // 2^16 = 15 mod 65521: fold the top nibble, then one conditional subtract
  function automatic logic [15:0] adl_fold(input logic [ADL_RAW_W-1:0] x);
    logic [16:0] t;
    t = 17'(x[15:0]) + 17'({x[19:16], 4'b0000}) - 17'(x[19:16]);
    if (t >= ADL_MOD) begin
      t = t - ADL_MOD;
    end
    return t[15:0];
  endfunction

endpackage

// ----- rtl/adl_lane.sv -----
// ----------------------------------------------------------------------------
// adl_lane
// One byte lane: masks the byte by the count and forms its weighted tap.
// ----------------------------------------------------------------------------
module adl_lane
  import adl_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic [7:0]           lane_byte,
  input  logic [ADL_CNT_W-1:0] count,
  output logic [7:0]           plain_o,
  output logic [11:0]          weighted_o
);

  logic                 active;
  logic [ADL_CNT_W-1:0] weight;

  assign active     = count > ADL_CNT_W'(IDX);
  assign weight     = active ? (count - ADL_CNT_W'(IDX)) : '0;
  assign plain_o    = active ? lane_byte : 8'd0;
  assign weighted_o = 12'(weight) * 12'(lane_byte);

endmodule

// ----- rtl/adl_merge.sv -----
// ----------------------------------------------------------------------------
// adl_merge
// Adds the lane results and registers them with the item's control fields.
// ----------------------------------------------------------------------------
module adl_merge
  import adl_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        s1_valid,
  input  adl_ctl_t    s1_ctl,
  input  logic [7:0]  plain_i    [LANES],
  input  logic [11:0] weighted_i [LANES],
  output logic        s2_valid_r,
  output adl_s2_t     s2_r
);

  logic [ADL_PLAIN_W-1:0] plain_sum;
  logic [ADL_WGT_W-1:0]   wgt_sum;

  always_comb begin
    plain_sum = '0;
    wgt_sum   = '0;
    for (int i = 0; i < LANES; i++) begin
      plain_sum = plain_sum + ADL_PLAIN_W'(plain_i[i]);
      wgt_sum   = wgt_sum + ADL_WGT_W'(weighted_i[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.ctl      <= s1_ctl;
      s2_r.plain    <= plain_sum;
      s2_r.weighted <= wgt_sum;
    end
  end

endmodule

// ----- rtl/adl_accum.sv -----
// ----------------------------------------------------------------------------
// adl_accum
// Holds sums a and b and applies one item's lane totals per cycle while upd is set.
// ----------------------------------------------------------------------------
module adl_accum
  import adl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd,
  input  adl_s2_t     s2,
  output logic [31:0] sum_nxt
);

  logic [15:0]          sum_low_r;
  logic [15:0]          sum_high_r;
  logic [15:0]          a_src;
  logic [15:0]          b_src;
  logic [ADL_RAW_W-1:0] n_times_a;
  logic [ADL_RAW_W-1:0] a_raw;
  logic [ADL_RAW_W-1:0] b_raw;
  logic [15:0]          a_nxt;
  logic [15:0]          b_nxt;

  assign a_src     = s2.ctl.first ? s2.ctl.seed[15:0]  : sum_low_r;
  assign b_src     = s2.ctl.first ? s2.ctl.seed[31:16] : sum_high_r;
  assign n_times_a = ADL_RAW_W'(a_src) * ADL_RAW_W'(s2.ctl.count);
  assign a_raw     = ADL_RAW_W'(a_src) + ADL_RAW_W'(s2.plain);
  assign b_raw     = ADL_RAW_W'(b_src) + n_times_a + ADL_RAW_W'(s2.weighted);
  assign a_nxt     = adl_fold(a_raw);
  assign b_nxt     = adl_fold(b_raw);
  assign sum_nxt   = {b_nxt, a_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_low_r  <= 16'd1;
      sum_high_r <= 16'd0;
    end else if (upd) begin
      sum_low_r  <= a_nxt;
      sum_high_r <= b_nxt;
    end
  end

endmodule

// ----- rtl/adler32_multilane_checksum.sv -----
// ----------------------------------------------------------------------------
// adler32_multilane_checksum
// Adler-32 over up to LANES bytes per transfer, with a per-lane tap stage.
// ----------------------------------------------------------------------------
// Input stream: in_tdata carries the data word, the valid byte count and the
// seed; in_tuser marks the first transfer of a message (load sums from the
// seed), in_tlast the final one. Byte 0 is the earliest. A count above LANES
// counts as LANES, bytes above the count are ignored.
// Output stream: one checksum {b, a} per transfer that had in_tlast set.
// Throughput: one transfer per cycle while not stalled. On its way to
// out_tvalid the checksum of a last transfer passes the input register, the
// lane adder tree register and the output register. The a/b update of the
// accumulator is the feedback loop, closed through the a and b registers.
// Reset (rst_n low, synchronous) empties the pipeline and sets a=1, b=0.
// Stall: while out_tdata waits, transfers keep flowing; in_tready drops only
// when a further last transfer reaches the accumulator with the output full.
// ----------------------------------------------------------------------------
module adler32_multilane_checksum
  import adl_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // data_word[63:0], valid_bytes[67:64], seed[99:68], 0
  input  logic         in_tuser,   // first
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // checksum[31:0]
);

  logic                 stall;
  logic                 adv;
  logic [ADL_CNT_W-1:0] in_count;
  logic [ADL_CNT_W-1:0] count_sat;

  logic                 s1_valid_r;
  logic [8*LANES-1:0]   s1_data_r;
  adl_ctl_t             s1_ctl_r;

  logic [7:0]           lane_plain [LANES];
  logic [11:0]          lane_wgt   [LANES];

  logic                 s2_valid_r;
  adl_s2_t              s2_r;
  logic [31:0]          sum_nxt;

  logic                 out_valid_r;
  logic [31:0]          out_data_r;

  assign stall     = s2_valid_r && s2_r.ctl.last && out_valid_r && !out_tready;
  assign adv       = !stall;
  assign in_tready = adv;

  assign in_count  = in_tdata[67:64];
  assign count_sat = (in_count > ADL_CNT_W'(LANES)) ? ADL_CNT_W'(LANES) : in_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_data_r      <= in_tdata[8*LANES-1:0];
      s1_ctl_r.count <= count_sat;
      s1_ctl_r.first <= in_tuser;
      s1_ctl_r.seed  <= in_tdata[99:68];
      s1_ctl_r.last  <= in_tlast;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    adl_lane #(
      .IDX(g)
    ) u_lane (
      .lane_byte (s1_data_r[8*g +: 8]),
      .count     (s1_ctl_r.count),
      .plain_o   (lane_plain[g]),
      .weighted_o(lane_wgt[g])
    );
  end

  adl_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_valid  (s1_valid_r),
    .s1_ctl    (s1_ctl_r),
    .plain_i   (lane_plain),
    .weighted_i(lane_wgt),
    .s2_valid_r(s2_valid_r),
    .s2_r      (s2_r)
  );

  adl_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (adv && s2_valid_r),
    .s2     (s2_r),
    .sum_nxt(sum_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s2_valid_r && s2_r.ctl.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_r.ctl.last) begin
      out_data_r <= sum_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/adl_checker.sv -----
// ----------------------------------------------------------------------------
// adl_checker
// Port-level checks for the Adler-32 block, bound to the top level.
// ----------------------------------------------------------------------------
module adl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled checksum transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  // both sums are always reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] < 16'd65521) && (out_tdata[31:16] < 16'd65521))
    else $error("checksum half not reduced");

  // input backpressure only comes from a blocked output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

endmodule

bind adler32_multilane_checksum adl_checker u_adl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
